// File: rtl/mme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix product engine
// Element widths, store geometry, action codes and the item that travels
// from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package mme_pkg;

  // Matrix geometry
  localparam int DIM         = 16;
  localparam int CELLS       = DIM * DIM;
  localparam int STORE_DEPTH = 256;

  // Field widths
  localparam int ACT_W  = 2;
  localparam int IDX_W  = 8;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 40;

  // Element address width: covers every row/column walk address plus the
  // store boundary, so an address beyond the store can be seen.
  localparam int ADDR_RAW = $clog2(CELLS + DIM);
  localparam int ADDR_W   = (ADDR_RAW > IDX_W + 1) ? ADDR_RAW : IDX_W + 1;

  // Step counter over one dot product
  localparam int K_W = (DIM > 1) ? $clog2(DIM) : 1;

  // Row = index / DIM by a ceiling reciprocal; exact for all 8-bit indices
  localparam int RECIP_SH = 16;
  localparam int RECIP    = ((2 ** RECIP_SH) + DIM - 1) / DIM;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int RPROD_W  = IDX_W + RECIP_W;

  // Queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // Action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_COMPUTE
  } op_kind_e;

  // Classified item held in the queue
  typedef struct packed {
    op_kind_e                  kind;
    logic [IDX_W-1:0]          idx;
    logic signed [ELEM_W-1:0]  value;
    logic [IDX_W-1:0]          row;
    logic                      in_range;
  } op_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/mme_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_front: input stage of the matrix product engine
// Accepts items, drops unused actions and loads beyond the matrix, works out
// the row of the index and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module mme_front import mme_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ACT_W-1:0]          action_i,
  input  logic [IDX_W-1:0]          elem_index_i,
  input  logic signed [ELEM_W-1:0]  elem_value_i,
  input  q_status_t                 q_status_i,
  output logic                      q_push_o,
  output op_t                       q_op_o
);

  logic                accept;
  logic                in_range;
  logic                keep;
  logic [RPROD_W-1:0]  row_prod;
  op_t                 op_cls;
  logic                fr_vld_q, fr_vld_d;
  op_t                 fr_op_q;

  // Stall only on a held item that the queue cannot take
  assign in_stall_o = fr_vld_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = fr_vld_q && !q_status_i.full;
  assign q_op_o     = fr_op_q;

  // Classify the incoming item
  assign in_range = ADDR_W'(elem_index_i) < ADDR_W'(CELLS);
  assign row_prod = RPROD_W'(elem_index_i) * RPROD_W'(RECIP);

  always_comb begin
    op_cls          = '0;
    op_cls.idx      = elem_index_i;
    op_cls.value    = elem_value_i;
    op_cls.row      = row_prod[RECIP_SH +: IDX_W];
    op_cls.in_range = in_range;
    keep            = 1'b0;
    case (action_i)
      ACT_LOAD_A: begin
        op_cls.kind = OP_LOAD_A;
        keep        = in_range;
      end
      ACT_LOAD_B: begin
        op_cls.kind = OP_LOAD_B;
        keep        = in_range;
      end
      ACT_COMPUTE: begin
        op_cls.kind = OP_COMPUTE;
        keep        = 1'b1;
      end
      default: begin
        op_cls.kind = OP_COMPUTE;
        keep        = 1'b0;
      end
    endcase
  end

  // Holding register valid
  always_comb begin
    fr_vld_d = fr_vld_q;
    if (accept) begin
      fr_vld_d = keep;
    end else if (q_push_o) begin
      fr_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q <= 1'b0;
    end else begin
      fr_vld_q <= fr_vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_op_q <= op_cls;
    end
  end

endmodule

// File: rtl/mme_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_queue: short item queue between front and back end
// Circular buffer of classified items with a fill count.
// ----------------------------------------------------------------------------
module mme_queue import mme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  op_t        push_op_i,
  input  logic       pop_i,
  output op_t        head_op_o,
  output q_status_t  status_o
);

  op_t              entry_q [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0]  count_q, count_d;

  assign status_o.full  = count_q == QC_W'(QUEUE_DEPTH);
  assign status_o.empty = count_q == '0;
  assign head_op_o      = entry_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// File: rtl/mme_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_back: execution stage of the matrix product engine
// Holds the A and B element stores, writes loads, and walks one row of A and
// one column of B through a pipelined multiply-accumulate for each compute.
// ----------------------------------------------------------------------------
module mme_back import mme_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  q_status_t                 q_status_i,
  input  op_t                       head_op_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [IDX_W-1:0]          result_index_o,
  output logic signed [ACC_W-1:0]   product_value_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [ELEM_W-1:0]         mem_a [STORE_DEPTH];
  logic [ELEM_W-1:0]         mem_b [STORE_DEPTH];

  logic [1:0]                state_q, state_d;
  logic [K_W-1:0]            k_q, k_d;
  logic [ADDR_W-1:0]         a_addr_q, a_addr_d;
  logic [ADDR_W-1:0]         b_addr_q, b_addr_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [IDX_W-1:0]          res_idx_q, res_idx_d;
  logic                      s1_vld_q, s1_vld_d;
  logic                      s1_zero_q, s1_zero_d;
  logic                      s2_vld_q;
  logic [ELEM_W-1:0]         a_rd_q, b_rd_q;
  logic signed [PROD_W-1:0]  mul;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      out_vld_q, out_vld_d;
  logic                      out_load;
  logic [IDX_W-1:0]          out_idx_q;
  logic signed [ACC_W-1:0]   out_val_q;
  logic                      wr_a, wr_b;
  logic [ADDR_W-1:0]         row_base;
  logic [ADDR_W-1:0]         col;

  assign out_valid_o     = out_vld_q;
  assign result_index_o  = out_idx_q;
  assign product_value_o = out_val_q;

  // Start addresses of the row walk in A and the column walk in B
  assign row_base = ADDR_W'(head_op_i.row) * ADDR_W'(DIM);
  assign col      = ADDR_W'(head_op_i.idx) - row_base;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    a_addr_d  = a_addr_q;
    b_addr_d  = b_addr_q;
    res_idx_d = res_idx_q;
    s1_vld_d  = 1'b0;
    s1_zero_d = 1'b0;
    q_pop_o   = 1'b0;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          q_pop_o = 1'b1;
          case (head_op_i.kind)
            OP_LOAD_A: wr_a = 1'b1;
            OP_LOAD_B: wr_b = 1'b1;
            OP_COMPUTE: begin
              res_idx_d = head_op_i.idx;
              k_d       = '0;
              a_addr_d  = row_base;
              b_addr_d  = col;
              state_d   = head_op_i.in_range ? ST_RUN : ST_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        // Issue one element pair per cycle
        s1_vld_d  = 1'b1;
        s1_zero_d = (a_addr_q >= ADDR_W'(STORE_DEPTH)) ||
                    (b_addr_q >= ADDR_W'(STORE_DEPTH));
        a_addr_d  = a_addr_q + 1'b1;
        b_addr_d  = b_addr_q + ADDR_W'(DIM);
        k_d       = k_q + 1'b1;
        if (k_q == K_W'(DIM - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Multiply and accumulate
  assign mul = PROD_W'($signed(a_rd_q)) * PROD_W'($signed(b_rd_q));

  always_comb begin
    acc_d = acc_q;
    if (state_q == ST_IDLE) begin
      acc_d = '0;
    end else if (s2_vld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  // Output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    a_addr_q  <= a_addr_d;
    b_addr_q  <= b_addr_d;
    res_idx_q <= res_idx_d;
    acc_q     <= acc_d;
    s1_zero_q <= s1_zero_d;
    prod_q    <= s1_zero_q ? '0 : mul;
    if (out_load) begin
      out_idx_q <= res_idx_q;
      out_val_q <= acc_q;
    end
  end

  // Element stores: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[head_op_i.idx] <= head_op_i.value;
    end
    a_rd_q <= mem_a[a_addr_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[head_op_i.idx] <= head_op_i.value;
    end
    b_rd_q <= mem_b[b_addr_q[IDX_W-1:0]];
  end

endmodule

// File: rtl/matrix_multiply_element.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_element: square matrix product engine, C = A x B
// Loads elements of A and B in signed Q8.8 and answers a compute item with
// one element of C as a signed Q24.16 dot product in 40 bits.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  input    in         in_valid_i/in_stall_o   action_i, elem_index_i,
//                                              elem_value_i
//  output   out        out_valid_o/out_stall_i result_index_o,
//                                              product_value_o
//
//  A load is written to its element store when the back end pops it. A
//  compute walks DIM steps through the single shared MAC, each reading one
//  element of A and one of B from their single read ports, then drains the
//  pipeline and hands off the result.
//  Reset clears control state only; the element stores hold no reset value.
//  A two-entry queue decouples intake from execution, so loads keep flowing
//  while a finished result waits in the output register.
//
module matrix_multiply_element import mme_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ACT_W-1:0]          action_i,
  input  logic [IDX_W-1:0]          elem_index_i,
  input  logic signed [ELEM_W-1:0]  elem_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [IDX_W-1:0]          result_index_o,
  output logic signed [ACC_W-1:0]   product_value_o
);

  q_status_t  q_status;
  logic       q_push;
  logic       q_pop;
  op_t        q_push_op;
  op_t        q_head_op;

  // Intake and classification
  mme_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .elem_index_i (elem_index_i),
    .elem_value_i (elem_value_i),
    .q_status_i   (q_status),
    .q_push_o     (q_push),
    .q_op_o       (q_push_op)
  );

  // Item queue
  mme_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (q_push_op),
    .pop_i     (q_pop),
    .head_op_o (q_head_op),
    .status_o  (q_status)
  );

  // Execution
  mme_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .head_op_i       (q_head_op),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_index_o  (result_index_o),
    .product_value_o (product_value_o)
  );

  // Front end never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_status.full))
    else $error("push into full queue");

  // Back end only pops a queue that holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // A pushed item is counted: the queue cannot read empty right after a push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |=> !q_status.empty)
    else $error("pushed item lost in queue");

endmodule
